>>> rtl/dtcf_pkg.sv
// ----------------------------------------------------------------------------
// dtcf_pkg: shared constants for the decimal text to clamped fixed converter
// Character codes, default parameter values and a power-of-ten helper.
// ----------------------------------------------------------------------------
package dtcf_pkg;

    // Default parameter values
    localparam int FRAC_DIGITS_DEF = 4;
    localparam int INT_BITS_DEF    = 16;
    localparam int MAX_FRAC_DIGITS = 4;
    localparam int MAX_INT_BITS    = 32;

    // Q16.16 format
    localparam int FRAC_BITS  = 16;
    localparam int VALUE_BITS = 32;
    localparam int WIDE_BITS  = MAX_INT_BITS + FRAC_BITS;

    // Configuration register indexes
    localparam logic CFG_MIN_SCALE = 1'b0;
    localparam logic CFG_MAX_SCALE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [VALUE_BITS-1:0] MIN_SCALE_RST = 32'd65536;
    localparam logic [VALUE_BITS-1:0] MAX_SCALE_RST = 32'd262144;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // 10^n for 0 <= n <= MAX_FRAC_DIGITS
    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 64'd1;
        for (int k = 0; k < MAX_FRAC_DIGITS; k++) begin
            if (k < n) begin
                p = p * 64'd10;
            end
        end
        return p;
    endfunction

endpackage

>>> rtl/decimal_text_to_clamped_fixed.sv
// ----------------------------------------------------------------------------
// decimal_text_to_clamped_fixed: decimal text to clamped Q16.16 value
// Parses digits, one point and an optional trailing x/X, one byte per beat,
// and gives one clamped Q16.16 result per string.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while the result channel does not stall;
// a new string may start the next cycle. After the last byte is taken the result
// beat passes the snapshot, reciprocal multiply and clamp/output registers.
// Reset (synchronous, active low) clears the parse state and the pipeline and
// loads min_scale = 1.0 and max_scale = 4.0.
module decimal_text_to_clamped_fixed #(
    parameter int FRAC_DIGITS = dtcf_pkg::FRAC_DIGITS_DEF,
    parameter int INT_BITS    = dtcf_pkg::INT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // text input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_scale_value,
    output logic        o_parse_ok,
    output logic        o_int_overflow
);
    import dtcf_pkg::*;

    // Fraction scaled to FRAC_DIGITS digits, then divided by 10^FRAC_DIGITS
    localparam longint unsigned DEN = pow10(FRAC_DIGITS);
    localparam int DBITS = $clog2(DEN);
    localparam int CBITS = $clog2(FRAC_DIGITS + 1);
    localparam int NBITS = FRAC_BITS + DBITS;
    localparam int SHIFT = NBITS + DBITS;
    localparam int MBITS = NBITS + 2;
    localparam int PBITS = NBITS + MBITS;
    localparam int IBITS = INT_BITS + 4;
    localparam logic [NBITS-1:0] HALF  = NBITS'(DEN / 2);
    localparam logic [MBITS-1:0] RECIP = MBITS'(((64'd1 << SHIFT) + DEN - 64'd1) / DEN);
    localparam logic [IBITS-1:0] INT_LIMIT = IBITS'({INT_BITS{1'b1}});

    // Configuration registers
    logic [VALUE_BITS-1:0] r_min_scale;
    logic [VALUE_BITS-1:0] r_max_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_scale <= MIN_SCALE_RST;
            r_max_scale <= MAX_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_SCALE: r_min_scale <= i_cfg_data;
                CFG_MAX_SCALE: r_max_scale <= i_cfg_data;
                default:       r_min_scale <= r_min_scale;
            endcase
        end
    end

    // Pipeline advances whenever the output register is free or drained
    logic adv;
    logic accept;
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;

    // Parse state
    logic               r_has_digit, r_has_point, r_suffix, r_failed, r_ended;
    logic               r_overflow;
    logic [INT_BITS-1:0] r_int;
    logic [DBITS-1:0]   r_frac;
    logic [CBITS-1:0]   r_count;

    logic               n_has_digit, n_has_point, n_suffix, n_failed, n_ended;
    logic               n_overflow;
    logic [INT_BITS-1:0] n_int;
    logic [DBITS-1:0]   n_frac;
    logic [CBITS-1:0]   n_count;

    logic               is_digit;
    logic [3:0]         digit;
    logic [IBITS-1:0]   int_step;
    logic [DBITS-1:0]   frac_weight;

    // Per-byte parse step
    always_comb begin
        is_digit    = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
        digit       = 4'(i_text_byte - CH_ZERO);
        int_step    = IBITS'({r_int, 3'b000}) + IBITS'({r_int, 1'b0}) + IBITS'(digit);
        frac_weight = DBITS'(pow10(FRAC_DIGITS - 1 - int'(r_count)));

        n_has_digit = r_has_digit;
        n_has_point = r_has_point;
        n_suffix     = r_suffix;
        n_failed     = r_failed;
        n_ended      = r_ended;
        n_overflow   = r_overflow;
        n_int        = r_int;
        n_frac       = r_frac;
        n_count      = r_count;

        priority if (r_ended || r_failed) begin
            n_ended = r_ended;
        end else if (i_text_byte == CH_NUL) begin
            n_ended = 1'b1;
        end else if (r_suffix) begin
            // nothing may follow the suffix
            n_failed = 1'b1;
        end else if (is_digit) begin
            n_has_digit = 1'b1;
            if (r_has_point) begin
                // extra fraction digits are checked but dropped
                if (r_count < CBITS'(FRAC_DIGITS)) begin
                    n_frac  = r_frac + DBITS'(frac_weight * DBITS'(digit));
                    n_count = r_count + CBITS'(1);
                end
            end else if (int_step > INT_LIMIT) begin
                n_int      = {INT_BITS{1'b1}};
                n_overflow = 1'b1;
            end else begin
                n_int = INT_BITS'(int_step);
            end
        end else if (i_text_byte == CH_POINT && !r_has_point) begin
            n_has_point = 1'b1;
        end else if ((i_text_byte == CH_LOW_X || i_text_byte == CH_UP_X) && r_has_digit) begin
            n_suffix = 1'b1;
        end else begin
            n_failed = 1'b1;
        end
    end

    // Parse state registers, cleared after the closing byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_byte)) begin
            r_has_digit <= 1'b0;
            r_has_point <= 1'b0;
            r_suffix     <= 1'b0;
            r_failed     <= 1'b0;
            r_ended      <= 1'b0;
            r_overflow   <= 1'b0;
            r_int        <= '0;
            r_frac       <= '0;
            r_count      <= '0;
        end else if (accept) begin
            r_has_digit <= n_has_digit;
            r_has_point <= n_has_point;
            r_suffix     <= n_suffix;
            r_failed     <= n_failed;
            r_ended      <= n_ended;
            r_overflow   <= n_overflow;
            r_int        <= n_int;
            r_frac       <= n_frac;
            r_count      <= n_count;
        end
    end

    // Stage 1: snapshot of the finished string
    logic                r_s1_valid;
    logic                r_s1_ok;
    logic                r_s1_ovf;
    logic [INT_BITS-1:0] r_s1_int;
    logic [DBITS-1:0]    r_s1_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept && i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ok   <= !n_failed && n_has_digit;
            r_s1_ovf  <= n_overflow;
            r_s1_int  <= n_int;
            r_s1_frac <= n_frac;
        end
    end

    // Stage 2: fraction = (frac * 2^16 + DEN/2) / DEN by exact reciprocal
    logic [NBITS-1:0]     numer;
    logic [PBITS-1:0]     prod;
    logic                 r_s2_valid;
    logic                 r_s2_ok;
    logic                 r_s2_ovf;
    logic [INT_BITS-1:0]  r_s2_int;
    logic [FRAC_BITS-1:0] r_s2_q;

    assign numer = {r_s1_frac, {FRAC_BITS{1'b0}}} + HALF;
    assign prod  = PBITS'(numer) * PBITS'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ok  <= r_s1_ok;
            r_s2_ovf <= r_s1_ovf;
            r_s2_int <= r_s1_int;
            r_s2_q   <= prod[SHIFT +: FRAC_BITS];
        end
    end

    // Stage 3: assemble, saturate to 32 bits, clamp
    logic [WIDE_BITS-1:0]  wide_value;
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] n_scale;

    always_comb begin
        wide_value = WIDE_BITS'({r_s2_int, r_s2_q});
        value = (|wide_value[WIDE_BITS-1:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                       : wide_value[VALUE_BITS-1:0];
        priority if (!r_s2_ok || !(value > r_min_scale)) begin
            n_scale = r_min_scale;
        end else if (value > r_max_scale) begin
            n_scale = r_max_scale;
        end else begin
            n_scale = value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_scale_value  <= n_scale;
            o_parse_ok     <= r_s2_ok;
            o_int_overflow <= r_s2_ok && r_s2_ovf;
        end
    end

endmodule
